// ===== hdl/hrp_pkg.sv =====
// hrp_pkg: shared types, character constants and match tables for the
// http response header parser; no dependencies
`default_nettype none

package hrp_pkg;

  // default header search window and body capacity after reset
  localparam int unsigned HEADER_MAX_DEF = 2048;
  localparam logic [15:0] CAP_RESET      = 16'd1024;

  // shortest header: idx of the last LF must reach 15 (header length 16)
  localparam int unsigned MIN_END_IDX = 15;

  // length key is LF plus 15 chars
  localparam logic [4:0] KEY_LEN    = 5'd16;
  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam logic [2:0] PREFIX_BAD = 3'd6;
  localparam logic [2:0] SEP_LEN    = 3'd4;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // number parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SKIP = 7'b0000001,
    PH_POS  = 7'b0000010,
    PH_NEG  = 7'b0000100,
    PH_DONE = 7'b0001000,
    PH_WAIT = 7'b0010000,
    PH_PEND = 7'b0100000,
    PH_SUSP = 7'b1000000
  } ph_t;

  // header unit result for the current word
  typedef struct packed {
    logic               done_old;
    logic               done;
    logic signed [15:0] status;
    logic signed [31:0] length;
  } hdr_res_t;

  // "\nContent-Length:" / "\ncontent-length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx, input logic upper);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CHAR_LF;
      4'd1:    ch = upper ? 8'h43 : 8'h63;
      4'd2:    ch = 8'h6f;
      4'd3:    ch = 8'h6e;
      4'd4:    ch = 8'h74;
      4'd5:    ch = 8'h65;
      4'd6:    ch = 8'h6e;
      4'd7:    ch = 8'h74;
      4'd8:    ch = 8'h2d;
      4'd9:    ch = upper ? 8'h4c : 8'h6c;
      4'd10:   ch = 8'h65;
      4'd11:   ch = 8'h6e;
      4'd12:   ch = 8'h67;
      4'd13:   ch = 8'h74;
      4'd14:   ch = 8'h68;
      default: ch = 8'h3a;
    endcase
    return ch;
  endfunction

  // "HTTP/"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      default: ch = 8'h2f;
    endcase
    return ch;
  endfunction

  // CR LF CR LF
  function automatic logic [7:0] sep_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

  // one step of a key matcher; restarts on LF
  function automatic logic [4:0] key_next(input logic [4:0] m, input logic [7:0] c,
                                          input logic upper);
    logic [4:0] r;
    if (m < KEY_LEN && c == key_char(m[3:0], upper)) begin
      r = m + 5'd1;
    end else begin
      r = (c == CHAR_LF) ? 5'd1 : 5'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hrp_num.sv =====
// hrp_num: one step of a saturating decimal parser (whitespace, sign, digits)
// depends on hrp_pkg
`default_nettype none

module hrp_num #(
  parameter int WIDTH = 16
) (
  input  wire  hrp_pkg::ph_t       phase_i,
  input  wire  logic signed [WIDTH-1:0] val_i,
  input  wire  logic [7:0]         c,
  output hrp_pkg::ph_t             phase_o,
  output logic signed [WIDTH-1:0]  val_o
);

  localparam int EW = WIDTH + 5;
  localparam logic signed [WIDTH-1:0] HI = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] LO = {1'b1, {(WIDTH-1){1'b0}}};

  logic                 dig;
  logic                 ws;
  logic signed [EW-1:0] v_ext;
  logic signed [EW-1:0] prod;
  logic signed [EW-1:0] d_ext;
  logic signed [EW-1:0] pos_sum;
  logic signed [EW-1:0] neg_sum;

  // character class
  always_comb begin
    dig = c inside {[8'h30:8'h39]};
    ws  = (c == hrp_pkg::CHAR_SP) || (c inside {[8'h09:8'h0d]});
  end

  // times ten plus or minus the digit, in a wider word
  assign v_ext   = EW'(val_i);
  assign prod    = (v_ext <<< 3) + (v_ext <<< 1);
  assign d_ext   = {{(EW-4){1'b0}}, c[3:0]};
  assign pos_sum = prod + d_ext;
  assign neg_sum = prod - d_ext;

  // phase step
  always_comb begin
    phase_o = phase_i;
    val_o   = val_i;
    case (phase_i)
      hrp_pkg::PH_SKIP: begin
        if (!ws) begin
          val_o = '0;
          if (c == hrp_pkg::CHAR_PLUS) begin
            phase_o = hrp_pkg::PH_POS;
          end else if (c == hrp_pkg::CHAR_MINUS) begin
            phase_o = hrp_pkg::PH_NEG;
          end else if (dig) begin
            phase_o = hrp_pkg::PH_POS;
            val_o   = WIDTH'(d_ext);
          end else begin
            phase_o = hrp_pkg::PH_DONE;
          end
        end
      end
      hrp_pkg::PH_POS: begin
        if (!dig) begin
          phase_o = hrp_pkg::PH_DONE;
        end else if (pos_sum > EW'(HI)) begin
          val_o = HI;
        end else begin
          val_o = WIDTH'(pos_sum);
        end
      end
      hrp_pkg::PH_NEG: begin
        if (!dig) begin
          phase_o = hrp_pkg::PH_DONE;
        end else if (neg_sum < EW'(LO)) begin
          val_o = LO;
        end else begin
          val_o = WIDTH'(neg_sum);
        end
      end
      default: begin
        phase_o = phase_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/hrp_hdr.sv =====
// hrp_hdr: header state of one stream: end search, prefix check, status and
// length parsers; depends on hrp_pkg and hrp_num
`default_nettype none

module hrp_hdr #(
  parameter int HEADER_MAX = hrp_pkg::HEADER_MAX_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              step,
  input  wire  logic [7:0]        c,
  input  wire  logic              byte_valid,
  input  wire  logic              last,
  output hrp_pkg::hdr_res_t       res
);

  localparam int CW = $clog2(HEADER_MAX + 1);

  logic                 done_r,  done_nxt;
  logic [CW-1:0]        cnt_r,   cnt_nxt;
  logic [1:0]           em_r,    em_nxt;
  logic [2:0]           ps_r,    ps_nxt;
  logic [4:0]           mu_r,    mu_nxt;
  logic [4:0]           ml_r,    ml_nxt;
  hrp_pkg::ph_t         sp_r,    sp_nxt;
  hrp_pkg::ph_t         lp_r,    lp_nxt;
  logic signed [15:0]   sv_r,    sv_nxt;
  logic signed [31:0]   lv_r,    lv_nxt;

  logic                 hb;
  logic [2:0]           em_ext;
  logic [2:0]           em_new;
  logic [2:0]           ps_new;
  logic [4:0]           mu_new;
  logic [4:0]           ml_new;
  logic                 cont;
  hrp_pkg::ph_t         sp_num, lp_feed, lp_num;
  hrp_pkg::ph_t         sp_new, lp_new;
  logic signed [15:0]   sv_num, sv_new;
  logic signed [31:0]   lv_num, lv_new;
  logic                 hdr_ok;
  logic                 len_ok;
  logic                 done_cur;
  logic signed [15:0]   sv_cur;
  logic signed [31:0]   lv_cur;

  // a header byte: valid, header still open and inside the search window
  assign hb = step && byte_valid && !done_r && (cnt_r < CW'(HEADER_MAX));

  // end-of-header and prefix matchers
  always_comb begin
    em_ext = {1'b0, em_r};
    if (c == hrp_pkg::sep_char(em_r)) begin
      em_new = em_ext + 3'd1;
    end else begin
      em_new = (c == hrp_pkg::CHAR_CR) ? 3'd1 : 3'd0;
    end
    cont = (em_new == em_ext + 3'd1);
    ps_new = ps_r;
    if (ps_r < hrp_pkg::PREFIX_LEN) begin
      ps_new = (c == hrp_pkg::prefix_char(ps_r)) ? ps_r + 3'd1 : hrp_pkg::PREFIX_BAD;
    end
  end

  // status parser
  hrp_num #(.WIDTH(16)) u_status (
    .phase_i (sp_r),
    .val_i   (sv_r),
    .c       (c),
    .phase_o (sp_num),
    .val_o   (sv_num)
  );

  // length parser: a CR after the key waits to see if the header ends there
  always_comb begin
    if ((lp_r == hrp_pkg::PH_PEND && c != hrp_pkg::CHAR_CR) ||
        (lp_r == hrp_pkg::PH_SUSP && !cont)) begin
      lp_feed = hrp_pkg::PH_SKIP;
    end else begin
      lp_feed = lp_r;
    end
  end

  hrp_num #(.WIDTH(32)) u_length (
    .phase_i (lp_feed),
    .val_i   (lv_r),
    .c       (c),
    .phase_o (lp_num),
    .val_o   (lv_num)
  );

  // per-byte update of both parsers
  always_comb begin
    sp_new = sp_num;
    sv_new = sv_num;
    if (sp_r == hrp_pkg::PH_WAIT) begin
      sp_new = sp_r;
      sv_new = sv_r;
      if (c == hrp_pkg::CHAR_SP) begin
        sp_new = hrp_pkg::PH_SKIP;
        sv_new = '0;
      end
    end

    mu_new = mu_r;
    ml_new = ml_r;
    lp_new = lp_num;
    lv_new = lv_num;
    case (lp_r)
      hrp_pkg::PH_WAIT: begin
        mu_new = hrp_pkg::key_next(mu_r, c, 1'b1);
        ml_new = hrp_pkg::key_next(ml_r, c, 1'b0);
        lp_new = lp_r;
        lv_new = lv_r;
        if (mu_new == hrp_pkg::KEY_LEN || ml_new == hrp_pkg::KEY_LEN) begin
          lp_new = hrp_pkg::PH_PEND;
          lv_new = '0;
        end
      end
      hrp_pkg::PH_PEND: begin
        if (c == hrp_pkg::CHAR_CR) begin
          lp_new = hrp_pkg::PH_SUSP;
          lv_new = lv_r;
        end
      end
      hrp_pkg::PH_SUSP: begin
        if (cont) begin
          lp_new = lp_r;
          lv_new = lv_r;
        end
      end
      default: begin
        lp_new = lp_num;
      end
    endcase

    // header end: check and freeze results
    hdr_ok = (cnt_r >= CW'(hrp_pkg::MIN_END_IDX)) && (ps_new == hrp_pkg::PREFIX_LEN) &&
             (sp_new != hrp_pkg::PH_WAIT);
    len_ok = hdr_ok && (lp_new == hrp_pkg::PH_SKIP || lp_new == hrp_pkg::PH_POS ||
                        lp_new == hrp_pkg::PH_NEG  || lp_new == hrp_pkg::PH_DONE);
  end

  // next state of the stream
  always_comb begin
    done_cur = done_r;
    cnt_nxt  = cnt_r;
    em_nxt   = em_r;
    ps_nxt   = ps_r;
    mu_nxt   = mu_r;
    ml_nxt   = ml_r;
    sp_nxt   = sp_r;
    lp_nxt   = lp_r;
    sv_cur   = sv_r;
    lv_cur   = lv_r;
    if (hb) begin
      cnt_nxt = cnt_r + CW'(1);
      em_nxt  = em_new[1:0];
      ps_nxt  = ps_new;
      mu_nxt  = mu_new;
      ml_nxt  = ml_new;
      sp_nxt  = sp_new;
      lp_nxt  = lp_new;
      sv_cur  = sv_new;
      lv_cur  = lv_new;
      if (em_new == hrp_pkg::SEP_LEN) begin
        done_cur = 1'b1;
        sp_nxt   = hrp_pkg::PH_DONE;
        lp_nxt   = hrp_pkg::PH_DONE;
        if (!hdr_ok) begin
          sv_cur = '0;
        end
        if (!len_ok) begin
          lv_cur = '1;
        end
      end
    end
    done_nxt = done_cur;
    sv_nxt   = sv_cur;
    lv_nxt   = lv_cur;
  end

  // result for this word
  always_comb begin
    res.done_old = done_r;
    res.done     = done_cur;
    res.status   = done_cur ? sv_cur : 16'sd0;
    res.length   = done_cur ? lv_cur : -32'sd1;
  end

  // stream state, cleared at reset and after the last word
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      done_r <= 1'b0;
      cnt_r  <= '0;
      em_r   <= '0;
      ps_r   <= '0;
      mu_r   <= '0;
      ml_r   <= '0;
      sp_r   <= hrp_pkg::PH_WAIT;
      lp_r   <= hrp_pkg::PH_WAIT;
      sv_r   <= '0;
      lv_r   <= '1;
    end else begin
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      em_r   <= em_nxt;
      ps_r   <= ps_nxt;
      mu_r   <= mu_nxt;
      ml_r   <= ml_nxt;
      sp_r   <= sp_nxt;
      lp_r   <= lp_nxt;
      sv_r   <= sv_nxt;
      lv_r   <= lv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/http_response_header_parser.sv =====
// http_response_header_parser: takes one response byte per word, finds the
// CR LF CR LF header end within the first HEADER_MAX bytes, checks the
// "HTTP/" prefix, parses the status after the first space and the first
// Content-Length value, then passes up to body_capacity body bytes. Every
// input word gives exactly one result word. It takes one word per cycle unless
// stalled; an accepted word sits in the input register and moves into the result
// register when that register is empty or its word is being taken.
// The input stalls only while both registers hold a word and the output is
// blocked. The path between them is the 32-bit times-ten add and saturating
// compare of the length parser. Depends on hrp_pkg and hrp_hdr.
`default_nettype none

module http_response_header_parser #(
  parameter int HEADER_MAX = hrp_pkg::HEADER_MAX_DEF
) (
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  // configuration
  input  wire  logic               cfg_wr_en,
  input  wire  logic [15:0]        cfg_wr_data,
  // input words
  input  wire  logic               in_valid,
  output logic                     in_ready,
  input  wire  logic [7:0]         in_data_byte,
  input  wire  logic               in_byte_valid,
  input  wire  logic               in_stream_end,
  // result words
  output logic                     out_valid,
  input  wire  logic               out_ready,
  output logic                     out_body_valid,
  output logic [7:0]               out_body_byte,
  output logic                     out_final_res,
  output logic                     out_header_found,
  output logic signed [15:0]       out_status_code,
  output logic signed [31:0]       out_content_length,
  output logic [15:0]              out_body_length
);

  logic [15:0]          body_cap_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_data_r;
  logic                 s1_bv_r;
  logic                 s1_last_r;
  logic                 advance;
  logic                 step;
  hrp_pkg::hdr_res_t    res;
  logic                 pass;
  logic [15:0]          body_cnt_r, body_cnt_nxt;
  logic [15:0]          body_cnt_cur;

  logic                 out_valid_r;
  logic                 out_body_valid_r;
  logic [7:0]           out_body_byte_r;
  logic                 out_final_r;
  logic                 out_found_r;
  logic signed [15:0]   out_status_r;
  logic signed [31:0]   out_length_r;
  logic [15:0]          out_blen_r;

  // body capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_cap_r <= hrp_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      body_cap_r <= cfg_wr_data;
    end
  end

  // pipeline flow: result register frees up or is taken this cycle
  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_bv_r   <= in_byte_valid;
      s1_last_r <= in_stream_end;
    end
  end

  // header state of the stream
  hrp_hdr #(.HEADER_MAX(HEADER_MAX)) u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .c          (s1_data_r),
    .byte_valid (s1_bv_r),
    .last       (s1_last_r),
    .res        (res)
  );

  // body pass-through and count
  assign pass         = s1_bv_r && res.done_old && (body_cnt_r < body_cap_r);
  assign body_cnt_cur = pass ? body_cnt_r + 16'd1 : body_cnt_r;
  assign body_cnt_nxt = s1_last_r ? 16'd0 : body_cnt_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_cnt_r <= '0;
    end else if (step) begin
      body_cnt_r <= body_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_body_valid_r <= pass;
      out_body_byte_r  <= pass ? s1_data_r : 8'd0;
      out_final_r      <= s1_last_r;
      out_found_r      <= res.done;
      out_status_r     <= res.status;
      out_length_r     <= res.length;
      out_blen_r       <= body_cnt_cur;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_body_valid     = out_body_valid_r;
  assign out_body_byte      = out_body_byte_r;
  assign out_final_res      = out_final_r;
  assign out_header_found   = out_found_r;
  assign out_status_code    = out_status_r;
  assign out_content_length = out_length_r;
  assign out_body_length    = out_blen_r;

  // body bytes only after the header end
  a_body_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_body_valid_r |-> out_found_r)
    else $error("body byte passed before header end");

  // no header: neutral results and no body
  a_no_hdr_defaults: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |->
      out_status_r == 16'sd0 && out_length_r == -32'sd1 && out_blen_r == 16'd0)
    else $error("results set without a header");

  // a dropped byte reads as zero
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_body_valid_r |-> out_body_byte_r == 8'd0)
    else $error("body byte not zero");

  // input stalls only when both stages hold a word and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

  // a word in the result register that is not taken stays there
  a_keep_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_blen_r))
    else $error("result lost under stall");

endmodule

`default_nettype wire
